@@ sv/dtrs_pkg.sv @@
// ----------------------------------------------------------------------------
// dtrs_pkg
// Shared constants, codes, state type and digit helper for the digit trie
// range-sum block.
// ----------------------------------------------------------------------------
package dtrs_pkg;

  localparam int MAX_DIGITS_DEF = 8;
  localparam int NODE_COUNT_DEF = 4096;
  localparam int KEY_BITS       = 32;
  localparam int VAL_BITS       = 32;
  localparam int SUM_BITS       = 64;
  localparam int ANS_BITS       = 63;
  localparam int RADIX          = 10;
  localparam int LEN_BITS       = 4;
  localparam int KEY_NIBBLES    = KEY_BITS / 4;

  localparam logic [LEN_BITS-1:0] LEN_RESET = LEN_BITS'(8);
  localparam logic [3:0]          DIGIT_MAX = 4'(RADIX - 1);

  localparam logic KIND_UPDATE = 1'b0;
  localparam logic KIND_QUERY  = 1'b1;
  localparam logic ST_OK       = 1'b0;
  localparam logic ST_FULL     = 1'b1;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    U_SCAN_RD,
    U_SCAN_CHK,
    U_BUILD_RD,
    U_BUILD_CHK,
    U_LEAF_RD,
    U_LEAF_WR,
    U_ANC_RD,
    U_ANC_WR,
    Q_ENTER,
    Q_SUM_RD,
    Q_SUM_ADD,
    Q_ROW_RD,
    Q_ROW_CHK,
    Q_NEXT,
    Q_POP
  } state_t;

  function automatic logic [3:0] digit_of(logic [KEY_BITS-1:0] key, logic [7:0] nib);
    logic [3:0] n;
    n = 4'd0;
    if (nib < 8'(KEY_NIBBLES)) begin
      n = key[nib[2:0]*4 +: 4];
    end
    return (n > DIGIT_MAX) ? DIGIT_MAX : n;
  endfunction

endpackage

@@ sv/dtrs_ram.sv @@
// ----------------------------------------------------------------------------
// dtrs_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module dtrs_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/dtrs_ctrl.sv @@
// ----------------------------------------------------------------------------
// dtrs_ctrl
// Sequencer for trie updates and range queries over the node-sum and
// child-link memories, with the clearing pass after reset.
// ----------------------------------------------------------------------------
module dtrs_ctrl #(
  parameter int MAX_DIGITS = dtrs_pkg::MAX_DIGITS_DEF,
  parameter int NODE_COUNT = dtrs_pkg::NODE_COUNT_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [$clog2(MAX_DIGITS+1)-1:0]     len,
  input  logic                                start,
  input  logic                                kind,
  input  logic [dtrs_pkg::KEY_BITS-1:0]       key_a,
  input  logic [dtrs_pkg::KEY_BITS-1:0]       key_b,
  input  logic [dtrs_pkg::VAL_BITS-1:0]       new_value,
  output logic                                busy,
  output logic                                done,
  output logic [dtrs_pkg::ANS_BITS-1:0]       answer,
  output logic                                status
);

  localparam int LW = $clog2(MAX_DIGITS + 1);
  localparam int NW = $clog2(NODE_COUNT);
  localparam int RW = dtrs_pkg::RADIX * NW;
  localparam int SW = dtrs_pkg::SUM_BITS;

  dtrs_pkg::state_t state, state_next;

  logic [dtrs_pkg::KEY_BITS-1:0] ka, ka_next, kb, kb_next;
  logic [dtrs_pkg::VAL_BITS-1:0] val, val_next;
  logic [LW-1:0]                 k, k_next, lvl, lvl_next;
  logic [NW-1:0]                 node, node_next, clr, clr_next;
  logic [NW:0]                   next_free, next_free_next;
  logic [NW-1:0]                 path [MAX_DIGITS+1];
  logic                          path_we;
  logic [LW-1:0]                 path_idx;
  logic [NW-1:0]                 path_val;
  logic [SW-1:0]                 old, old_next, delta, delta_next, acc, acc_next;
  logic [3:0]                    dig, dig_next;
  logic                          bh, bh_next, al, al_next;
  logic [NW-1:0]                 fnode [MAX_DIGITS+1];
  logic [3:0]                    fd [MAX_DIGITS+1];
  logic                          fbh [MAX_DIGITS+1];
  logic                          fal [MAX_DIGITS+1];
  logic                          fr_we, fd_we;
  logic [3:0]                    fd_val;
  logic                          done_next, status_next;
  logic [dtrs_pkg::ANS_BITS-1:0] answer_next;

  logic          sum_we, link_we;
  logic [NW-1:0] sum_waddr, sum_raddr, link_waddr, link_raddr;
  logic [SW-1:0] sum_wdata, sum_rdata;
  logic [RW-1:0] link_wdata, link_rdata;

  logic [3:0]    ud, dl, dr, nl, nr;
  logic [NW-1:0] child;
  logic          ea, eb, emid;
  logic [LW-1:0] missing;

  dtrs_ram #(.WIDTH(SW), .DEPTH(NODE_COUNT)) u_sum (
    .clk(clk), .we(sum_we), .waddr(sum_waddr), .wdata(sum_wdata),
    .raddr(sum_raddr), .rdata(sum_rdata)
  );

  dtrs_ram #(.WIDTH(RW), .DEPTH(NODE_COUNT)) u_link (
    .clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
    .raddr(link_raddr), .rdata(link_rdata)
  );

  assign busy = (state != dtrs_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= dtrs_pkg::S_CLEAR;
      clr       <= '0;
      next_free <= (NW+1)'(1);
      done      <= 1'b0;
    end else begin
      state     <= state_next;
      clr       <= clr_next;
      next_free <= next_free_next;
      done      <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    ka     <= ka_next;
    kb     <= kb_next;
    val    <= val_next;
    k      <= k_next;
    lvl    <= lvl_next;
    node   <= node_next;
    old    <= old_next;
    delta  <= delta_next;
    acc    <= acc_next;
    dig    <= dig_next;
    bh     <= bh_next;
    al     <= al_next;
    answer <= answer_next;
    status <= status_next;
    if (path_we) begin
      path[path_idx] <= path_val;
    end
    if (fr_we) begin
      fnode[lvl] <= node;
      fbh[lvl]   <= bh;
      fal[lvl]   <= al;
    end
    if (fd_we) begin
      fd[lvl] <= fd_val;
    end
  end

  always_comb begin
    state_next     = state;
    ka_next        = ka;
    kb_next        = kb;
    val_next       = val;
    k_next         = k;
    lvl_next       = lvl;
    node_next      = node;
    clr_next       = clr;
    next_free_next = next_free;
    old_next       = old;
    delta_next     = delta;
    acc_next       = acc;
    dig_next       = dig;
    bh_next        = bh;
    al_next        = al;
    done_next      = 1'b0;
    answer_next    = answer;
    status_next    = status;
    path_we        = 1'b0;
    path_idx       = k;
    path_val       = '0;
    fr_we          = 1'b0;
    fd_we          = 1'b0;
    fd_val         = 4'd0;
    sum_we         = 1'b0;
    sum_waddr      = node;
    sum_wdata      = '0;
    sum_raddr      = node;
    link_we        = 1'b0;
    link_waddr     = node;
    link_wdata     = link_rdata;
    link_raddr     = node;
    missing        = LW'(len - k);

    ud   = dtrs_pkg::digit_of(ka, 8'(LW'(len - k - LW'(1))));
    dl   = (lvl != '0) ? dtrs_pkg::digit_of(ka, 8'(LW'(len - lvl))) : 4'd0;
    dr   = (lvl != '0) ? dtrs_pkg::digit_of(kb, 8'(LW'(len - lvl))) : 4'd0;
    nl   = dtrs_pkg::digit_of(ka, 8'(LW'(len - lvl - LW'(1))));
    nr   = dtrs_pkg::digit_of(kb, 8'(LW'(len - lvl - LW'(1))));
    ea   = al || (dl <= dig);
    eb   = bh || (dig <= dr);
    emid = (al || (dl < dig)) && (bh || (dig < dr));
    child = link_rdata[ud*NW +: NW];

    case (state)
      dtrs_pkg::S_CLEAR: begin
        sum_we     = 1'b1;
        sum_waddr  = clr;
        link_we    = 1'b1;
        link_waddr = clr;
        link_wdata = '0;
        clr_next   = clr + NW'(1);
        if (clr == NW'(NODE_COUNT - 1)) begin
          state_next = dtrs_pkg::S_IDLE;
        end
      end
      dtrs_pkg::S_IDLE: begin
        if (start) begin
          ka_next   = key_a;
          kb_next   = key_b;
          val_next  = new_value;
          k_next    = '0;
          lvl_next  = '0;
          node_next = '0;
          dig_next  = 4'd0;
          bh_next   = 1'b0;
          al_next   = 1'b0;
          acc_next  = '0;
          path_we   = 1'b1;
          path_idx  = '0;
          path_val  = '0;
          state_next = (kind == dtrs_pkg::KIND_QUERY) ? dtrs_pkg::Q_ENTER
                                                      : dtrs_pkg::U_SCAN_RD;
        end
      end
      dtrs_pkg::U_SCAN_RD: begin
        state_next = dtrs_pkg::U_SCAN_CHK;
      end
      dtrs_pkg::U_SCAN_CHK: begin
        if (child == '0) begin
          if ((NW+2)'(next_free) + (NW+2)'(missing) > (NW+2)'(NODE_COUNT)) begin
            answer_next = '0;
            status_next = dtrs_pkg::ST_FULL;
            done_next   = 1'b1;
            state_next  = dtrs_pkg::S_IDLE;
          end else begin
            k_next     = '0;
            node_next  = '0;
            state_next = dtrs_pkg::U_BUILD_RD;
          end
        end else if (k == LW'(len - LW'(1))) begin
          k_next     = '0;
          node_next  = '0;
          state_next = dtrs_pkg::U_BUILD_RD;
        end else begin
          node_next  = child;
          k_next     = k + LW'(1);
          state_next = dtrs_pkg::U_SCAN_RD;
        end
      end
      dtrs_pkg::U_BUILD_RD: begin
        state_next = dtrs_pkg::U_BUILD_CHK;
      end
      dtrs_pkg::U_BUILD_CHK: begin
        path_we  = 1'b1;
        path_idx = k + LW'(1);
        if (child == '0) begin
          link_we                    = 1'b1;
          link_wdata[ud*NW +: NW]    = next_free[NW-1:0];
          next_free_next             = next_free + (NW+1)'(1);
          path_val                   = next_free[NW-1:0];
          node_next                  = next_free[NW-1:0];
        end else begin
          path_val  = child;
          node_next = child;
        end
        k_next = k + LW'(1);
        state_next = (k == LW'(len - LW'(1))) ? dtrs_pkg::U_LEAF_RD : dtrs_pkg::U_BUILD_RD;
      end
      dtrs_pkg::U_LEAF_RD: begin
        sum_raddr  = path[len];
        state_next = dtrs_pkg::U_LEAF_WR;
      end
      dtrs_pkg::U_LEAF_WR: begin
        old_next   = sum_rdata;
        delta_next = SW'(val) - sum_rdata;
        sum_we     = 1'b1;
        sum_waddr  = path[len];
        sum_wdata  = SW'(val);
        k_next     = '0;
        state_next = dtrs_pkg::U_ANC_RD;
      end
      dtrs_pkg::U_ANC_RD: begin
        sum_raddr  = path[k];
        state_next = dtrs_pkg::U_ANC_WR;
      end
      dtrs_pkg::U_ANC_WR: begin
        sum_we    = 1'b1;
        sum_waddr = path[k];
        sum_wdata = sum_rdata + delta;
        k_next    = k + LW'(1);
        if (k == LW'(len - LW'(1))) begin
          answer_next = old[dtrs_pkg::ANS_BITS-1:0];
          status_next = dtrs_pkg::ST_OK;
          done_next   = 1'b1;
          state_next  = dtrs_pkg::S_IDLE;
        end else begin
          state_next = dtrs_pkg::U_ANC_RD;
        end
      end
      dtrs_pkg::Q_ENTER: begin
        if (lvl == len) begin
          state_next = (ea && eb) ? dtrs_pkg::Q_SUM_RD : dtrs_pkg::Q_POP;
        end else if (emid) begin
          state_next = dtrs_pkg::Q_SUM_RD;
        end else if (!ea || !eb) begin
          state_next = dtrs_pkg::Q_POP;
        end else begin
          fr_we      = 1'b1;
          fd_we      = 1'b1;
          fd_val     = 4'd0;
          state_next = dtrs_pkg::Q_ROW_RD;
        end
      end
      dtrs_pkg::Q_SUM_RD: begin
        state_next = dtrs_pkg::Q_SUM_ADD;
      end
      dtrs_pkg::Q_SUM_ADD: begin
        acc_next   = acc + sum_rdata;
        state_next = dtrs_pkg::Q_POP;
      end
      dtrs_pkg::Q_ROW_RD: begin
        link_raddr = fnode[lvl];
        state_next = dtrs_pkg::Q_ROW_CHK;
      end
      dtrs_pkg::Q_ROW_CHK: begin
        if (link_rdata[fd[lvl]*NW +: NW] != '0) begin
          node_next  = link_rdata[fd[lvl]*NW +: NW];
          dig_next   = fd[lvl];
          bh_next    = fbh[lvl] || (fd[lvl] < nr);
          al_next    = fal[lvl] || (fd[lvl] > nl);
          lvl_next   = lvl + LW'(1);
          state_next = dtrs_pkg::Q_ENTER;
        end else begin
          state_next = dtrs_pkg::Q_NEXT;
        end
      end
      dtrs_pkg::Q_NEXT: begin
        if (fd[lvl] == dtrs_pkg::DIGIT_MAX) begin
          state_next = dtrs_pkg::Q_POP;
        end else begin
          fd_we      = 1'b1;
          fd_val     = fd[lvl] + 4'd1;
          state_next = dtrs_pkg::Q_ROW_RD;
        end
      end
      dtrs_pkg::Q_POP: begin
        if (lvl == '0) begin
          answer_next = acc[dtrs_pkg::ANS_BITS-1:0];
          status_next = dtrs_pkg::ST_OK;
          done_next   = 1'b1;
          state_next  = dtrs_pkg::S_IDLE;
        end else begin
          lvl_next   = lvl - LW'(1);
          state_next = dtrs_pkg::Q_NEXT;
        end
      end
      default: begin
        state_next = dtrs_pkg::S_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_done_from_work: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) != dtrs_pkg::S_IDLE && $past(state) != dtrs_pkg::S_CLEAR)
    else $error("result strobe without work in progress");
  a_full_answer: assert property (@(posedge clk) disable iff (rst)
    (done && status == dtrs_pkg::ST_FULL) |-> answer == '0)
    else $error("refused update with nonzero answer");
  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    next_free <= (NW+1)'(NODE_COUNT))
    else $error("node allocation past store size");
  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    (state == dtrs_pkg::Q_ENTER) |-> lvl <= len)
    else $error("query level past key length");
`endif

endmodule

@@ sv/digit_trie_range_sum_top.sv @@
// ----------------------------------------------------------------------------
// digit_trie_range_sum_top
// Decimal-digit trie with per-node subtree sums: point update, range sum.
// ----------------------------------------------------------------------------
// Update: scan and build walks over the child-link memory one level at a time, a leaf
// read-write, then a read-add-write per ancestor in the sum memory; a refused update
// ends after the scan walk.
// Query: walks the boundary paths, reading each child slot, entering children and
// summing nodes inside the range; one transaction at a time, no stall on results.
// Reset runs a clearing pass over all NODE_COUNT nodes with busy high.
// ----------------------------------------------------------------------------
module digit_trie_range_sum_top #(
  parameter int MAX_DIGITS = dtrs_pkg::MAX_DIGITS_DEF,
  parameter int NODE_COUNT = dtrs_pkg::NODE_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          kind,
  input  logic [dtrs_pkg::KEY_BITS-1:0] key_a,
  input  logic [dtrs_pkg::KEY_BITS-1:0] key_b,
  input  logic [dtrs_pkg::VAL_BITS-1:0] new_value,
  output logic                          done,
  output logic [dtrs_pkg::ANS_BITS-1:0] answer,
  output logic                          status,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [dtrs_pkg::LEN_BITS-1:0] cfg_data
);

  localparam int LW = $clog2(MAX_DIGITS + 1);
  localparam int CW = (LW > dtrs_pkg::LEN_BITS) ? LW : dtrs_pkg::LEN_BITS;

  logic [dtrs_pkg::LEN_BITS-1:0] key_length;
  logic [CW-1:0]                 kl_ext;
  logic [LW-1:0]                 len;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_length <= dtrs_pkg::LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      key_length <= cfg_data;
    end
  end

  always_comb begin
    kl_ext = CW'(key_length);
    if (kl_ext == '0) begin
      len = LW'(1);
    end else if (kl_ext > CW'(MAX_DIGITS)) begin
      len = LW'(MAX_DIGITS);
    end else begin
      len = LW'(kl_ext);
    end
  end

  dtrs_ctrl #(.MAX_DIGITS(MAX_DIGITS), .NODE_COUNT(NODE_COUNT)) u_ctrl (
    .clk(clk), .rst(rst), .len(len), .start(start), .kind(kind),
    .key_a(key_a), .key_b(key_b), .new_value(new_value),
    .busy(busy), .done(done), .answer(answer), .status(status)
  );

endmodule

@@ tb/tb_digit_trie_range_sum_top.sv @@
// ----------------------------------------------------------------------------
// tb_digit_trie_range_sum_top
// Self-checking bench for the digit trie range-sum block: a directed table
// of updates and queries, then random traffic, checked against a local
// trie model with subtree sums across several key lengths.
// ----------------------------------------------------------------------------
module tb_digit_trie_range_sum_top;

  localparam int NODES = dtrs_pkg::NODE_COUNT_DEF;
  localparam int MAXD  = dtrs_pkg::MAX_DIGITS_DEF;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          start = 1'b0;
  logic                          busy;
  logic                          kind = dtrs_pkg::KIND_UPDATE;
  logic [dtrs_pkg::KEY_BITS-1:0] key_a = '0;
  logic [dtrs_pkg::KEY_BITS-1:0] key_b = '0;
  logic [dtrs_pkg::VAL_BITS-1:0] new_value = '0;
  logic                          done;
  logic [dtrs_pkg::ANS_BITS-1:0] answer;
  logic                          status;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [dtrs_pkg::LEN_BITS-1:0] cfg_data = '0;

  digit_trie_range_sum_top dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .kind(kind),
    .key_a(key_a), .key_b(key_b), .new_value(new_value), .done(done),
    .answer(answer), .status(status), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  typedef struct packed {
    logic [dtrs_pkg::ANS_BITS-1:0] ans;
    logic                          st;
  } trie_answer_t;

  typedef struct {
    logic                          k;
    logic [dtrs_pkg::KEY_BITS-1:0] a;
    logic [dtrs_pkg::KEY_BITS-1:0] b;
    logic [dtrs_pkg::VAL_BITS-1:0] v;
    bit                            fixed;
    trie_answer_t                  want;
  } trie_cmd_t;

  logic [dtrs_pkg::SUM_BITS-1:0] subtree_sum [NODES];
  int unsigned                   child_of [NODES*dtrs_pkg::RADIX];
  int unsigned                   free_node;
  logic [dtrs_pkg::LEN_BITS-1:0] len_reg;
  trie_answer_t                  pending [$];
  int                            errors = 0;

  function automatic int unsigned key_len();
    if (len_reg == 0) return 1;
    if (len_reg > MAXD) return MAXD;
    return len_reg;
  endfunction

  function automatic int unsigned dig(logic [dtrs_pkg::KEY_BITS-1:0] key, int k,
      int unsigned n);
    logic [3:0] nib;
    int p;
    p = n - 1 - k;
    nib = key[p*4 +: 4];
    return (nib > 9) ? 9 : nib;
  endfunction

  function automatic logic [dtrs_pkg::SUM_BITS-1:0] span_sum(
      logic [dtrs_pkg::KEY_BITS-1:0] lo, logic [dtrs_pkg::KEY_BITS-1:0] hi,
      int unsigned n, bit bh, bit al, int pos, int unsigned node, int unsigned d);
    int unsigned dl, dr, c;
    bit ga, gb, mid;
    logic [dtrs_pkg::SUM_BITS-1:0] acc;
    dl = 0; dr = 0; acc = '0;
    if (pos >= 0) begin
      dl = dig(lo, pos, n);
      dr = dig(hi, pos, n);
    end
    ga = al || dl <= d;
    gb = bh || d <= dr;
    if (pos == int'(n) - 1) return (ga && gb) ? subtree_sum[node] : '0;
    mid = (al || dl < d) && (bh || d < dr);
    if (mid) return subtree_sum[node];
    if (!ga || !gb) return '0;
    for (int e = 0; e < dtrs_pkg::RADIX; e++) begin
      c = child_of[node*dtrs_pkg::RADIX + e];
      if (c != 0)
        acc += span_sum(lo, hi, n, bh || e < dig(hi, pos+1, n),
                        al || e > dig(lo, pos+1, n), pos + 1, c, e);
    end
    return acc;
  endfunction

  function automatic trie_answer_t apply_cmd(trie_cmd_t c);
    trie_answer_t r;
    int unsigned n, node, missing, slot;
    int unsigned path [MAXD+1];
    logic [dtrs_pkg::SUM_BITS-1:0] old, delta;
    n = key_len();
    r.st = dtrs_pkg::ST_OK;
    if (c.k == dtrs_pkg::KIND_QUERY) begin
      old = span_sum(c.a, c.b, n, 1'b0, 1'b0, -1, 0, 0);
      r.ans = old[dtrs_pkg::ANS_BITS-1:0];
      return r;
    end
    node = 0; missing = 0;
    for (int k = 0; k < n; k++) begin
      slot = child_of[node*dtrs_pkg::RADIX + dig(c.a, k, n)];
      if (slot == 0) begin
        missing = n - k;
        break;
      end
      node = slot;
    end
    if (missing > 0 && free_node + missing > NODES) begin
      r.ans = '0;
      r.st = dtrs_pkg::ST_FULL;
      return r;
    end
    node = 0; path[0] = 0;
    for (int k = 0; k < n; k++) begin
      slot = node*dtrs_pkg::RADIX + dig(c.a, k, n);
      if (child_of[slot] == 0) child_of[slot] = free_node++;
      node = child_of[slot];
      path[k+1] = node;
    end
    old = subtree_sum[path[n]];
    delta = {32'd0, c.v} - old;
    subtree_sum[path[n]] = {32'd0, c.v};
    for (int k = 0; k < n; k++) subtree_sum[path[k]] += delta;
    r.ans = old[dtrs_pkg::ANS_BITS-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending.size() == 0) begin
        $display("%0t: expected no result, actual answer=%0h status=%0b",
                 $time, answer, status);
        errors++;
      end else begin
        trie_answer_t w;
        w = pending.pop_front();
        if (w.ans !== answer) begin
          $display("%0t: answer expected %0h actual %0h", $time, w.ans, answer);
          errors++;
        end
        if (w.st !== status) begin
          $display("%0t: status expected %0b actual %0b", $time, w.st, status);
          errors++;
        end
      end
    end
  end

  task automatic issue(trie_cmd_t c);
    trie_answer_t w;
    int gap;
    gap = $urandom_range(0, 15);
    @(negedge clk);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
      if (gap > 1) @(negedge clk);
    end
    kind <= c.k; key_a <= c.a; key_b <= c.b; new_value <= c.v;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    w = apply_cmd(c);
    if (c.fixed && w !== c.want) begin
      $display("%0t: table row expected %0h actual model %0h", $time, c.want, w);
      errors++;
    end
    pending = {pending, w};
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_len(logic [dtrs_pkg::LEN_BITS-1:0] n);
    drain();
    @(negedge clk);
    cfg_data <= n;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    len_reg = n;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [dtrs_pkg::KEY_BITS-1:0] rand_key(int unsigned n, bit noisy);
    logic [dtrs_pkg::KEY_BITS-1:0] k;
    k = '0;
    for (int i = 0; i < dtrs_pkg::KEY_NIBBLES; i++)
      k[i*4 +: 4] = (noisy || i >= n) ? 4'($urandom_range(0, 15))
                                       : 4'($urandom_range(0, 9));
    return k;
  endfunction

  function automatic trie_cmd_t rand_cmd(int unsigned n);
    trie_cmd_t c;
    bit noisy;
    noisy = ($urandom_range(0, 9) == 0);
    c.k = 1'($urandom_range(0, 1));
    c.a = rand_key(n, noisy);
    c.b = rand_key(n, noisy);
    if (c.k == dtrs_pkg::KIND_QUERY && c.a > c.b && $urandom_range(0, 3) != 0) begin
      logic [dtrs_pkg::KEY_BITS-1:0] t;
      t = c.a; c.a = c.b; c.b = t;
    end
    case ($urandom_range(0, 3))
      0: c.v = '1;
      1: c.v = $urandom_range(0, 100);
      default: c.v = $urandom();
    endcase
    c.fixed = 1'b0;
    c.want = '0;
    return c;
  endfunction

  trie_cmd_t table_rows [$];

  function automatic trie_cmd_t row(logic k, logic [31:0] a, logic [31:0] b,
      logic [31:0] v, bit fx, logic [dtrs_pkg::ANS_BITS-1:0] ans);
    trie_cmd_t c;
    c.k = k; c.a = a; c.b = b; c.v = v; c.fixed = fx;
    c.want.ans = ans; c.want.st = dtrs_pkg::ST_OK;
    return c;
  endfunction

  initial begin
    for (int i = 0; i < NODES; i++) subtree_sum[i] = '0;
    for (int i = 0; i < NODES*dtrs_pkg::RADIX; i++) child_of[i] = 0;
    free_node = 1;
    len_reg = dtrs_pkg::LEN_RESET;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    table_rows = {table_rows, row(dtrs_pkg::KIND_QUERY, 32'h0000_0000, 32'h9999_9999,
                                  '0, 1'b1, '0)};
    table_rows = {table_rows, row(dtrs_pkg::KIND_UPDATE, 32'h0000_0000, '0,
                                  32'hFFFF_FFFF, 1'b1, '0)};
    table_rows = {table_rows, row(dtrs_pkg::KIND_UPDATE, 32'h9999_9999, '0,
                                  32'hFFFF_FFFF, 1'b1, '0)};
    table_rows = {table_rows, row(dtrs_pkg::KIND_UPDATE, 32'hFFFF_FFFF, '0, 32'd5,
                                  1'b1, 63'hFFFF_FFFF)};
    table_rows = {table_rows, row(dtrs_pkg::KIND_QUERY, 32'h0000_0000, 32'hFFFF_FFFF,
                                  '0, 1'b1, 63'h1_0000_0004)};
    table_rows = {table_rows, row(dtrs_pkg::KIND_QUERY, 32'h9999_9999, 32'h0000_0000,
                                  '0, 1'b1, '0)};
    table_rows = {table_rows, row(dtrs_pkg::KIND_UPDATE, 32'h1234_5678, '0,
                                  32'hA5A5_5A5A, 1'b1, '0)};
    table_rows = {table_rows, row(dtrs_pkg::KIND_UPDATE, 32'h1234_5678, '0, 32'd7,
                                  1'b1, 63'hA5A5_5A5A)};
    table_rows = {table_rows, row(dtrs_pkg::KIND_QUERY, 32'h1234_5678, 32'h1234_5678,
                                  '0, 1'b1, 63'd7)};
    table_rows = {table_rows, row(dtrs_pkg::KIND_QUERY, 32'h1234_0000, 32'h1299_9999,
                                  '0, 1'b0, '0)};
    table_rows = {table_rows, row(dtrs_pkg::KIND_QUERY, 32'hABCD_EF01, 32'h5555_5555,
                                  '0, 1'b0, '0)};
    foreach (table_rows[i]) issue(table_rows[i]);

    set_len(4'd1);
    for (int d = 0; d < 12; d++)
      issue(row(d[0], {28'd0, 4'(d)}, 32'd9, 32'(d * 3), 1'b0, '0));
    set_len(4'd0);
    issue(row(dtrs_pkg::KIND_QUERY, 32'd0, 32'd9, '0, 1'b0, '0));
    set_len(4'd15);
    issue(row(dtrs_pkg::KIND_QUERY, 32'd0, 32'hFFFF_FFFF, '0, 1'b0, '0));

    for (int i = 0; i < 800; i++) begin
      if (i % 200 == 0) set_len(4'($urandom_range(0, 15)));
      if (i == 100) drain();
      issue(rand_cmd(key_len()));
    end

    // fill the node store until updates are refused
    set_len(4'd8);
    for (int i = 0; i < 400 && free_node + 8 <= NODES; i++)
      issue(row(dtrs_pkg::KIND_UPDATE, rand_key(8, 1'b0), '0, $urandom(), 1'b0, '0));
    for (int i = 0; i < 20; i++)
      issue(row(dtrs_pkg::KIND_UPDATE, rand_key(8, 1'b0), '0, $urandom(), 1'b0, '0));
    for (int i = 0; i < 6; i++) issue(rand_cmd(8));

    drain();
    repeat (200) @(posedge clk);
    if (errors == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  initial begin
    #400000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

@@ filelist.f @@
sv/dtrs_pkg.sv
sv/dtrs_ram.sv
sv/dtrs_ctrl.sv
sv/digit_trie_range_sum_top.sv
tb/tb_digit_trie_range_sum_top.sv
